// File: hw/rtl/psf_pkg.sv
package psf_pkg;

   // Field widths of the access and result items
   localparam int ADDR_W     = 64;
   localparam int TIME_W     = 48;
   localparam int INTERVAL_W = 32;

   // Layout of one way entry: superpage tag over a 4 KiB page bitmap
   localparam int ENTRY_W  = 64;
   localparam int MAP_W    = 16;
   localparam int TAG_LSB  = 16;
   localparam int TAG_W    = ENTRY_W - TAG_LSB;
   localparam int PAGE_LSB = 12;
   localparam int PAGE_W   = 4;

   localparam logic [INTERVAL_W-1:0] CLEAR_INTERVAL_RESET = 32'd60000;

   // Control sequencer
   typedef enum logic [1:0] {
      S_IDLE,
      S_INDEX,
      S_LOOK
   } state_type;

   // Outcome of the way compare
   typedef struct packed {
      logic hit;
      logic seen;
   } lookup_res_type;

endpackage

// File: hw/rtl/psf_req_if.sv
interface psf_req_if;
   import psf_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   address;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, output address, output now_ms, input ready);
   modport sink   (input valid, input address, input now_ms, output ready);

endinterface

// File: hw/rtl/psf_rsp_if.sv
interface psf_rsp_if;

   logic valid;
   logic ready;
   logic already_seen;
   logic table_cleared;

   modport source (output valid, output already_seen, output table_cleared, input ready);
   modport sink   (input valid, input already_seen, input table_cleared, output ready);

endinterface

// File: hw/rtl/psf_ram.sv
module psf_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/psf_index.sv
module psf_index
   import psf_pkg::*;
#(
   parameter int SETS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [TAG_W-1:0]                      superpage,
   output logic                                  done,
   output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] index
);

   localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;

   logic             done_ff;
   logic [IDX_W-1:0] rem_ff;

   generate
      if ((SETS & (SETS - 1)) == 0) begin : g_pow2
         // Power-of-two set count: take the low bits of the superpage number
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= (SETS == 1) ? '0 : superpage[IDX_W-1:0];
            end
         end
      end else begin : g_fold
         // Folded sum stays below 2^FOLD_W; the reciprocal is exact over that range
         localparam int FOLD_W = IDX_W + 18;
         localparam int SHIFT  = FOLD_W + IDX_W;
         localparam int QUOT_W = FOLD_W - IDX_W + 1;
         localparam logic [IDX_W-1:0]  W1_C    = IDX_W'((64'd1 << 16) % SETS);
         localparam logic [IDX_W-1:0]  W2_C    = IDX_W'((64'd1 << 32) % SETS);
         localparam logic [FOLD_W:0]   RECIP_C =
            (FOLD_W + 1)'(((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS));
         localparam logic [IDX_W:0]    SETS_C  = (IDX_W + 1)'(SETS);

         logic [1:0]            stage_ff;
         logic [16+IDX_W-1:0]   mid_prod;
         logic [16+IDX_W-1:0]   high_prod;
         logic [FOLD_W-1:0]     fold_in;
         logic [FOLD_W-1:0]     fold_ff;
         logic [FOLD_W-1:0]     keep_ff;
         logic [2*FOLD_W:0]     prod_ff;
         logic [QUOT_W-1:0]     quot;
         logic [FOLD_W+1:0]     back;
         logic [FOLD_W-1:0]     diff;

         // Fold the 16-bit chunks with their weights 2^16 and 2^32 modulo the set count
         assign mid_prod  = superpage[31:16] * W1_C;
         assign high_prod = superpage[47:32] * W2_C;
         assign fold_in   = FOLD_W'(superpage[15:0]) + FOLD_W'(mid_prod) +
                            FOLD_W'(high_prod);

         // Quotient from the reciprocal product, remainder by subtracting it back
         assign quot = prod_ff[2*FOLD_W:SHIFT];
         assign back = quot * SETS_C;
         assign diff = keep_ff - back[FOLD_W-1:0];

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= '0;
               done_ff  <= 1'b0;
            end else begin
               stage_ff <= {stage_ff[0], start};
               done_ff  <= stage_ff[1];
            end
         end

         // Advance the fold, the multiply and the remainder as successive registered stages
         always_ff @(posedge clock) begin
            if (start) begin
               fold_ff <= fold_in;
            end
            if (stage_ff[0]) begin
               prod_ff <= fold_ff * RECIP_C;
               keep_ff <= fold_ff;
            end
            if (stage_ff[1]) begin
               rem_ff <= diff[IDX_W-1:0];
            end
         end
      end
   endgenerate

   assign done  = done_ff;
   assign index = rem_ff;

endmodule

// File: hw/rtl/psf_lookup.sv
module psf_lookup
   import psf_pkg::*;
#(
   parameter int WAYS = 4
) (
   input  logic [WAYS*ENTRY_W-1:0] row,
   input  logic [TAG_W-1:0]        tag,
   input  logic [PAGE_W-1:0]       page,
   output logic [WAYS*ENTRY_W-1:0] new_row,
   output lookup_res_type          res
);

   logic [MAP_W-1:0] page_bit;

   assign page_bit = MAP_W'(1) << page;

   // Compare ways from way 0; first match wins, else shift in at way 0
   always_comb begin
      res     = '0;
      new_row = row;
      for (int w = 0; w < WAYS; w++) begin
         if (!res.hit && (row[w*ENTRY_W+TAG_LSB +: TAG_W] == tag)) begin
            res.hit  = 1'b1;
            res.seen = |(row[w*ENTRY_W +: MAP_W] & page_bit);
            new_row[w*ENTRY_W +: MAP_W] = row[w*ENTRY_W +: MAP_W] | page_bit;
         end
      end
      if (!res.hit) begin
         for (int w = WAYS - 1; w > 0; w--) begin
            new_row[w*ENTRY_W +: ENTRY_W] = row[(w-1)*ENTRY_W +: ENTRY_W];
         end
         new_row[ENTRY_W-1:0] = {tag, page_bit};
      end
   end

endmodule

// File: hw/rtl/page_seen_filter_cache_top.sv
// One access at a time. With SETS a power of two the set index is registered,
// then the set is read, then the row is compared, written back and the result
// registered; the next access is taken only after the write-back. Otherwise the
// set index passes through folding sum, reciprocal multiply and remainder first.
// A waiting result holds the write-back, and with it the next access.
// Reset (synchronous) marks every set empty and zeroes the last clear time.
module page_seen_filter_cache_top
   import psf_pkg::*;
#(
   parameter int SETS = 32,
   parameter int WAYS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   psf_req_if.sink               req,
   psf_rsp_if.source             rsp,
   input  logic                  csr_write_en,
   input  logic [INTERVAL_W-1:0] csr_write_data
);

   localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int ROW_W = WAYS * ENTRY_W;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     addr_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [TIME_W-1:0]     last_clear_ff;
   logic [SETS-1:0]       valid_ff, valid_in;
   logic                  rsp_valid_ff;
   logic                  seen_ff;
   logic                  cleared_ff;

   logic                  accept;
   logic                  idx_done;
   logic [IDX_W-1:0]      idx;
   logic                  rd_en;
   logic                  commit;
   logic                  out_free;
   logic [ROW_W-1:0]      rd_row;
   logic [ROW_W-1:0]      cur_row;
   logic [ROW_W-1:0]      new_row;
   logic [TIME_W:0]       elapsed;
   logic                  expire;
   lookup_res_type        res;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Set index unit
   psf_index #(.SETS(SETS)) u_index (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .superpage (req.address[TAG_LSB +: TAG_W]),
      .done      (idx_done),
      .index     (idx)
   );

   // Set store, one row of all ways per set
   psf_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (idx),
      .wr_data (new_row),
      .rd_en   (rd_en),
      .rd_addr (idx),
      .rd_data (rd_row)
   );

   // Expiry test: signed difference strictly above the interval
   assign elapsed = {1'b0, now_ff} - {1'b0, last_clear_ff};
   assign expire  = !elapsed[TIME_W] &&
                    (elapsed[TIME_W-1:0] > TIME_W'(interval_ff));

   // Empty or freshly cleared sets read as zero
   assign cur_row = (expire || !valid_ff[idx]) ? '0 : rd_row;

   psf_lookup #(.WAYS(WAYS)) u_lookup (
      .row     (cur_row),
      .tag     (addr_ff[TAG_LSB +: TAG_W]),
      .page    (addr_ff[PAGE_LSB +: PAGE_W]),
      .new_row (new_row),
      .res     (res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_INDEX;
            end
         end
         S_INDEX: begin
            if (idx_done) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req.ready = 1'b0;
      rd_en     = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         S_IDLE:  req.ready = 1'b1;
         S_INDEX: rd_en     = idx_done;
         S_LOOK:  commit    = out_free;
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the accepted access
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req.address;
         now_ff  <= req.now_ms;
      end
   end

   // Clear interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= CLEAR_INTERVAL_RESET;
      end else if (csr_write_en) begin
         interval_ff <= csr_write_data;
      end
   end

   // Set valid bits: drop all on expiry, mark the written set
   always_comb begin
      valid_in = valid_ff;
      if (commit) begin
         if (expire) begin
            valid_in = '0;
         end
         valid_in[idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         last_clear_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (commit && expire) begin
            last_clear_ff <= now_ff;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         seen_ff    <= res.seen;
         cleared_ff <= expire;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.already_seen  = seen_ff;
   assign rsp.table_cleared = cleared_ff;

endmodule
